### rtl/sha1e_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 engine package
// Transaction types, control bundle and constants shared by the engine files.
// ----------------------------------------------------------------------------
package sha1e_pkg;

   localparam int BLOCK_BYTES  = 64;
   localparam int WINDOW_WORDS = 16;
   localparam int CHAIN_WORDS  = 5;

   localparam logic [4:0] DIGEST_BYTES = 5'd20;
   localparam logic [7:0] PAD_BYTE     = 8'h80;
   localparam logic [6:0] LAST_ROUND   = 7'd79;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hEFCDAB89;
   localparam logic [31:0] IV2 = 32'h98BADCFE;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hC3D2E1F0;

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       finish;
   } sha1e_req_type;

   typedef struct packed {
      logic [7:0] digest_byte;
      logic [4:0] byte_index;
      logic       last;
   } sha1e_rsp_type;

   typedef logic [CHAIN_WORDS-1:0][31:0] sha1e_chain_type;

   // Commands from the sequencer to the compression core.
   typedef struct packed {
      logic        byte_we;
      logic        pad_we;
      logic        len_we;
      logic        clear_all;
      logic        start;
      logic        chain_init;
      logic [5:0]  byte_pos;
      logic [7:0]  byte_data;
      logic [31:0] msg_len;
   } sha1e_ctl_type;

endpackage
`default_nettype wire

### rtl/sha1_hash_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Streams message bytes into 64-byte blocks, pads on finish and returns the
// digest one byte per transaction.
// ----------------------------------------------------------------------------
//  Channel  Ports                          Direction  Carries
//  req      req_valid req_stall req_data   in         message byte, finish
//  rsp      rsp_valid rsp_stall rsp_data   out        digest byte, index, last
//  csr      csr_valid csr_ready csr_data   in         digest length
//
// A byte that does not complete a block is taken without a stall. The 64th
// byte of a block holds off further requests while the block runs 80 rounds
// in the shared round unit and is added into the chaining value. Finish adds
// a padding step and one more compression, two when the tail leaves no room
// for the length. Digest bytes follow one per cycle while rsp_stall is low.
// After reset the chaining value holds the initial words and length is 20.
// ----------------------------------------------------------------------------
module sha1_hash_engine
   import sha1e_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  sha1e_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output sha1e_rsp_type rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [4:0]    csr_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_COMP = 3'd1;
   localparam logic [2:0] ST_PAD  = 3'd2;
   localparam logic [2:0] ST_LEN  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   localparam logic [1:0] AFT_IDLE = 2'd0;
   localparam logic [1:0] AFT_PAD  = 2'd1;
   localparam logic [1:0] AFT_LEN  = 2'd2;
   localparam logic [1:0] AFT_EMIT = 2'd3;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  after_ff, after_in;
   logic [5:0]  fill_ff, fill_in;
   logic [31:0] count_ff, count_in;
   logic [4:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [4:0]  dlen_ff;

   sha1e_ctl_type   ctl;
   sha1e_chain_type chain;
   logic            core_done;
   logic            req_acc, rsp_acc;
   logic [4:0]      n_bytes;
   logic [31:0]     word;

   sha1e_core u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .done  (core_done),
      .chain (chain)
   );

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid_ff && !rsp_stall;
   assign n_bytes = (dlen_ff > DIGEST_BYTES) ? DIGEST_BYTES : dlen_ff;

   always_comb begin
      state_in     = state_ff;
      after_in     = after_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      ctl          = '0;
      ctl.byte_pos  = fill_ff;
      ctl.byte_data = req_data.data_byte;
      ctl.msg_len   = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_data.byte_valid) begin
                  ctl.byte_we = 1'b1;
                  fill_in     = fill_ff + 6'd1;
                  count_in    = count_ff + 32'd1;
               end
               if (req_data.byte_valid && (fill_ff == 6'(BLOCK_BYTES - 1))) begin
                  ctl.start = 1'b1;
                  state_in  = ST_COMP;
                  after_in  = req_data.finish ? AFT_PAD : AFT_IDLE;
               end else if (req_data.finish) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            ctl.pad_we = 1'b1;
            ctl.start  = 1'b1;
            state_in   = ST_COMP;
            // Fewer than eight bytes left means the length needs a block of its own.
            if (fill_ff < 6'(BLOCK_BYTES - 8)) begin
               ctl.len_we = 1'b1;
               after_in   = AFT_EMIT;
            end else begin
               after_in = AFT_LEN;
            end
         end
         ST_LEN: begin
            ctl.clear_all = 1'b1;
            ctl.len_we    = 1'b1;
            ctl.start     = 1'b1;
            state_in      = ST_COMP;
            after_in      = AFT_EMIT;
         end
         ST_COMP: begin
            if (core_done) begin
               case (after_ff)
                  AFT_IDLE: state_in = ST_IDLE;
                  AFT_PAD:  state_in = ST_PAD;
                  AFT_LEN:  state_in = ST_LEN;
                  AFT_EMIT: begin
                     if (n_bytes == 5'd0) begin
                        ctl.chain_init = 1'b1;
                        fill_in        = 6'd0;
                        count_in       = 32'd0;
                        state_in       = ST_IDLE;
                     end else begin
                        idx_in       = 5'd0;
                        rsp_valid_in = 1'b1;
                        state_in     = ST_EMIT;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_EMIT: begin
            if (rsp_acc) begin
               if (rsp_data.last) begin
                  rsp_valid_in   = 1'b0;
                  ctl.chain_init = 1'b1;
                  fill_in        = 6'd0;
                  count_in       = 32'd0;
                  state_in       = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      case (idx_ff[4:2])
         3'd0:    word = chain[0];
         3'd1:    word = chain[1];
         3'd2:    word = chain[2];
         3'd3:    word = chain[3];
         3'd4:    word = chain[4];
         default: word = 32'd0;
      endcase
      rsp_data.digest_byte = word[31 - 8*idx_ff[1:0] -: 8];
      rsp_data.byte_index  = idx_ff;
      rsp_data.last        = (idx_ff == (n_bytes - 5'd1));
   end

   always_ff @(posedge clock) begin
      after_ff <= after_in;
      idx_ff   <= idx_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= 6'd0;
         count_ff     <= 32'd0;
         rsp_valid_ff <= 1'b0;
         dlen_ff      <= DIGEST_BYTES;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            dlen_ff <= csr_data;
         end
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

`ifndef ASSERT_OFF
   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("digest transaction offered while taking requests");

   a_last_frees_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last) |=> !req_stall)
      else $error("engine not ready after last digest transaction");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.byte_index < DIGEST_BYTES))
      else $error("digest index beyond digest");

   a_done_in_comp: assert property (@(posedge clock) disable iff (reset)
      core_done |-> (state_ff == ST_COMP))
      else $error("compression finished outside compression state");
`endif

endmodule
`default_nettype wire

### rtl/sha1e_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 compression core
// Block window, round variables and chaining value; one round per cycle.
// ----------------------------------------------------------------------------
module sha1e_core
   import sha1e_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  sha1e_ctl_type   ctl,
   output logic            done,
   output sha1e_chain_type chain
);

   logic [31:0]     win_ff [WINDOW_WORDS];
   logic [31:0]     win_in [WINDOW_WORDS];
   sha1e_chain_type vars_ff, vars_in;
   sha1e_chain_type chain_ff, chain_in;
   logic [6:0]      rnd_ff, rnd_in;
   logic            busy_ff, busy_in;
   logic            add_ff, add_in;

   logic [31:0] a, b, c, d, e, f, k, tmp, x, w_new;

   // Round function; the window doubles as the rolling message schedule.
   always_comb begin
      a = vars_ff[0];
      b = vars_ff[1];
      c = vars_ff[2];
      d = vars_ff[3];
      e = vars_ff[4];
      if (rnd_ff < 7'd20) begin
         f = (b & c) | (~b & d);
         k = K0;
      end else if (rnd_ff < 7'd40) begin
         f = b ^ c ^ d;
         k = K1;
      end else if (rnd_ff < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
         k = K2;
      end else begin
         f = b ^ c ^ d;
         k = K3;
      end
      tmp   = {a[26:0], a[31:27]} + f + e + win_ff[0] + k;
      x     = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
      w_new = {x[30:0], x[31]};
   end

   always_comb begin
      for (int i = 0; i < WINDOW_WORDS; i++) begin
         win_in[i] = win_ff[i];
      end
      if (busy_ff) begin
         for (int i = 0; i < WINDOW_WORDS - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[WINDOW_WORDS-1] = w_new;
      end else begin
         for (int w = 0; w < WINDOW_WORDS; w++) begin
            for (int l = 0; l < 4; l++) begin
               if (ctl.clear_all) begin
                  win_in[w][31-8*l -: 8] = 8'h00;
               end
               if (ctl.pad_we && (6'(4*w + l) == ctl.byte_pos)) begin
                  win_in[w][31-8*l -: 8] = PAD_BYTE;
               end
               if (ctl.pad_we && (6'(4*w + l) > ctl.byte_pos)) begin
                  win_in[w][31-8*l -: 8] = 8'h00;
               end
               if (ctl.byte_we && (6'(4*w + l) == ctl.byte_pos)) begin
                  win_in[w][31-8*l -: 8] = ctl.byte_data;
               end
            end
         end
         // The bit length is the byte count times eight, in the last 64 bits.
         if (ctl.len_we) begin
            win_in[WINDOW_WORDS-2] = {29'd0, ctl.msg_len[31:29]};
            win_in[WINDOW_WORDS-1] = {ctl.msg_len[28:0], 3'b000};
         end
      end
   end

   always_comb begin
      vars_in  = vars_ff;
      chain_in = chain_ff;
      rnd_in   = rnd_ff;
      busy_in  = busy_ff;
      add_in   = 1'b0;
      if (ctl.start) begin
         vars_in = chain_ff;
         rnd_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         vars_in = {d, c, {b[1:0], b[31:2]}, a, tmp};
         if (rnd_ff == LAST_ROUND) begin
            busy_in = 1'b0;
            add_in  = 1'b1;
         end else begin
            rnd_in = rnd_ff + 7'd1;
         end
      end
      if (add_ff) begin
         for (int i = 0; i < CHAIN_WORDS; i++) begin
            chain_in[i] = chain_ff[i] + vars_ff[i];
         end
      end
      if (ctl.chain_init) begin
         chain_in = {IV4, IV3, IV2, IV1, IV0};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW_WORDS; i++) begin
         win_ff[i] <= win_in[i];
      end
      vars_ff <= vars_in;
      rnd_ff  <= rnd_in;
      if (reset) begin
         busy_ff  <= 1'b0;
         add_ff   <= 1'b0;
         chain_ff <= {IV4, IV3, IV2, IV1, IV0};
      end else begin
         busy_ff  <= busy_in;
         add_ff   <= add_in;
         chain_ff <= chain_in;
      end
   end

   assign done  = add_ff;
   assign chain = chain_ff;

endmodule
`default_nettype wire

### dv/sha1_digest_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 digest checker
// Watches the request, response and length-register channels, keeps its own
// copy of the hash state, works out the digest bytes that each accepted request
// produces and compares every accepted response against the oldest one due.
// ----------------------------------------------------------------------------
module sha1_digest_checker
   import sha1e_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_stall,
   input  sha1e_req_type req_data,
   input  logic          rsp_valid,
   input  logic          rsp_stall,
   input  sha1e_rsp_type rsp_data,
   input  logic          csr_valid,
   input  logic          csr_ready,
   input  logic [4:0]    csr_data,
   output int            fail_count,
   output int            pending_bytes
);

   logic [31:0]   chain_word [CHAIN_WORDS];
   logic [7:0]    block_byte [BLOCK_BYTES];
   logic [6:0]    fill_level;
   logic [31:0]   msg_bytes;
   logic [4:0]    digest_len;
   sha1e_rsp_type digest_due [$];

   initial begin
      fail_count    = 0;
      pending_bytes = 0;
   end

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void start_message();
      chain_word[0] = IV0;
      chain_word[1] = IV1;
      chain_word[2] = IV2;
      chain_word[3] = IV3;
      chain_word[4] = IV4;
      fill_level    = '0;
      msg_bytes     = '0;
   endfunction

   // One 80-round pass over the current block, folded into the chaining value.
   function automatic void compress_block();
      logic [31:0] w [WINDOW_WORDS];
      logic [31:0] a, b, c, d, e, f, k, t32;
      int          t;
      for (t = 0; t < WINDOW_WORDS; t++) begin
         w[t] = {block_byte[4*t], block_byte[4*t+1], block_byte[4*t+2], block_byte[4*t+3]};
      end
      a = chain_word[0];
      b = chain_word[1];
      c = chain_word[2];
      d = chain_word[3];
      e = chain_word[4];
      for (t = 0; t < 80; t++) begin
         if (t >= 16) begin
            w[t % 16] = rotl32(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16]
                               ^ w[t % 16], 1);
         end
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = K0;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = K1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K2;
         end else begin
            f = b ^ c ^ d;
            k = K3;
         end
         t32 = rotl32(a, 5) + f + e + w[t % 16] + k;
         e   = d;
         d   = c;
         c   = rotl32(b, 30);
         b   = a;
         a   = t32;
      end
      chain_word[0] += a;
      chain_word[1] += b;
      chain_word[2] += c;
      chain_word[3] += d;
      chain_word[4] += e;
   endfunction

   function automatic void absorb_request(input sha1e_req_type req);
      sha1e_rsp_type item;
      logic [31:0]   word;
      int            pos;
      int            n;
      int            i;
      if (req.byte_valid) begin
         block_byte[fill_level[5:0]] = req.data_byte;
         msg_bytes  = msg_bytes + 1;
         fill_level = fill_level + 1;
         if (fill_level == BLOCK_BYTES) begin
            compress_block();
            fill_level = '0;
         end
      end
      if (!req.finish) return;

      pos = fill_level;
      block_byte[pos] = PAD_BYTE;
      for (i = pos + 1; i < BLOCK_BYTES; i++) block_byte[i] = 8'h00;
      // With no room left for the length, the padding spills into a second block.
      if (pos >= 56) begin
         compress_block();
         for (i = 0; i < BLOCK_BYTES; i++) block_byte[i] = 8'h00;
      end
      block_byte[59] = {5'b0, msg_bytes[31:29]};
      block_byte[60] = msg_bytes[28:21];
      block_byte[61] = msg_bytes[20:13];
      block_byte[62] = msg_bytes[12:5];
      block_byte[63] = {msg_bytes[4:0], 3'b000};
      compress_block();

      n = (digest_len > DIGEST_BYTES) ? DIGEST_BYTES : digest_len;
      for (i = 0; i < n; i++) begin
         word             = chain_word[i / 4];
         item.digest_byte = 8'(word >> (8 * (3 - (i % 4))));
         item.byte_index  = 5'(i);
         item.last        = (i == n - 1);
         digest_due.push_back(item);
      end
      start_message();
   endfunction

   always @(posedge clock) begin : watch
      sha1e_rsp_type want;
      if (reset) begin
         start_message();
         digest_len = DIGEST_BYTES;
         digest_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_due.size() == 0) begin
               $error("digest byte %02h at index %0d arrived with none due",
                      rsp_data.digest_byte, rsp_data.byte_index);
               fail_count++;
            end else begin
               want = digest_due.pop_front();
               if (rsp_data.digest_byte !== want.digest_byte) begin
                  $error("digest_byte: expected %02h, got %02h",
                         want.digest_byte, rsp_data.digest_byte);
                  fail_count++;
               end
               if (rsp_data.byte_index !== want.byte_index) begin
                  $error("byte_index: expected %0d, got %0d",
                         want.byte_index, rsp_data.byte_index);
                  fail_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_data.last);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) digest_len = csr_data;
         if (req_valid && !req_stall) absorb_request(req_data);
      end
      pending_bytes = digest_due.size();
   end

endmodule

### dv/tb_sha1_hash_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 hash engine testbench
// Drives message bytes, finish requests and digest-length writes into the
// engine with random gaps and response back-pressure; the checker beside the
// engine predicts and compares every digest byte.
// ----------------------------------------------------------------------------
module tb_sha1_hash_engine;
   import sha1e_pkg::*;

   localparam int ITEM_TARGET   = 320;
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 3000;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   sha1e_req_type req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   sha1e_rsp_type rsp_data;
   logic          csr_valid;
   logic          csr_ready;
   logic [4:0]    csr_data;
   int            fail_count;
   int            pending_bytes;

   int            items_sent;
   int            quiet_cycles;
   logic          sender_steady;
   logic          hold_rsp;

   sha1_hash_engine u_top (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_data
   );

   sha1_digest_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_data,
      .fail_count, .pending_bytes
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Ends the run if no transaction completes on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL sha1_hash_engine");
         $finish;
      end
   end

   // Response side: a random stall before each digest byte, runs without stalls,
   // and one long hold-off on request so that the engine backs up.
   initial begin : receiver
      int   gap;
      logic steady;
      rsp_stall = 1'b0;
      steady    = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         if ($urandom_range(0, 15) == 0) steady = ~steady;
         gap = steady ? 0 : $urandom_range(0, 11);
         repeat (gap) begin
            rsp_stall <= 1'b1;
            @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid || hold_rsp)) @(posedge clock);
      end
   end

   // Entered and left at a falling edge; valid stays up until the caller moves on.
   task automatic send_item(input logic [7:0] data, input logic bv, input logic fin);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 11);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {data, bv, fin};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (bv || fin) items_sent++;
      @(negedge clock);
   endtask

   task automatic send_message(input int len);
      logic tail_finish;
      int   i;
      sender_steady = ($urandom_range(0, 3) == 0);
      tail_finish   = (len > 0) && ($urandom_range(0, 1) == 1);
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 7) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(8'($urandom_range(0, 255)), 1'b1, tail_finish && (i == len - 1));
      end
      if (!tail_finish) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // Mostly short messages, with lengths around the padding boundaries and a
   // few spanning more than one block.
   function automatic int pick_length();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) return $urandom_range(0, 12);
      if (sel < 8) begin
         case ($urandom_range(0, 3))
            0:       return 55;
            1:       return 56;
            2:       return 63;
            default: return 64;
         endcase
      end
      return $urandom_range(13, 130);
   endfunction

   task automatic write_length(input logic [4:0] len);
      csr_valid <= 1'b1;
      csr_data  <= len;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // A finish with zero length leaves nothing due while the engine still
   // compresses, so the pause covers two full compressions.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_bytes != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      int phase;
      int phase_start;
      int len;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      hold_rsp      = 1'b0;
      sender_steady = 1'b0;
      items_sent    = 0;
      quiet_cycles  = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset length of twenty bytes.
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'hA5, 1'b0, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h5A, 1'b0, 1'b1);
      settle();
      write_length(5'd0);
      send_item(8'h11, 1'b1, 1'b1);
      send_item(8'h22, 1'b0, 1'b1);
      settle();
      write_length(5'd31);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b1);
      settle();
      write_length(5'd1);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h7F, 1'b1, 1'b1);
      settle();

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase)
            0:       len = 20;
            1:       len = 0;
            2:       len = 31;
            3:       len = 19;
            4:       len = 1;
            default: len = $urandom_range(0, 31);
         endcase
         write_length(5'(len));
         if (phase == 0) begin
            hold_rsp = 1'b1;
            repeat (6) send_message($urandom_range(1, 3));
         end
         phase_start = items_sent;
         while ((items_sent - phase_start < 36) && (items_sent < ITEM_TARGET)) begin
            send_message(pick_length());
         end
         settle();
         phase++;
      end

      if (fail_count == 0 && pending_bytes == 0) begin
         $display("PASS sha1_hash_engine");
      end else begin
         $display("FAIL sha1_hash_engine");
      end
      $finish;
   end

endmodule
